// ----- rtl/core/pcr_pkg.sv -----
// Package for the capture file record counter: widths, header constants and
// the byte swap helper. No dependencies.
package pcr_pkg;

  localparam int unsigned TOTAL_WIDTH_DEF = 48;
  localparam int unsigned TOTAL_WIDTH_MAX = 64;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned PAYLOAD_W = 48;

  // m_tdata layout: packet_count, payload_total, header_complete, zero fill
  localparam int unsigned OUT_FIELDS_W = COUNT_W + PAYLOAD_W + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [WORD_W-1:0]  LE_MAGIC   = 32'hd4c3_b2a1;
  localparam logic [INDEX_W-1:0] GLOBAL_LAST = INDEX_W'(23);
  localparam logic [INDEX_W-1:0] MAGIC_LAST  = INDEX_W'(3);
  localparam logic [INDEX_W-1:0] RECORD_LAST = INDEX_W'(15);
  localparam logic [INDEX_W-1:0] LEN_FIRST   = INDEX_W'(8);
  localparam logic [INDEX_W-1:0] LEN_LAST    = INDEX_W'(11);

  function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ----- rtl/core/pcap_record_counter.sv -----
// Capture file record counter: parses the global header and record headers
// of a byte stream and reports record count and payload total per file.
// Depends on pcr_pkg.
//
//  channel | dir | beat        | payload
//  s_*     | in  | one byte    | s_tdata: data_byte; s_tlast: end_of_stream
//  m_*     | out | one result  | m_tdata: see m_tdata comment below
//
// One byte per cycle; parse state updates in the cycle the word is accepted.
// A result is written to the output register as the last byte is accepted.
// The output register holds a result until m_tready takes it;
// input stalls only when a result is held and m_tready is low.
// rst (synchronous) returns all parse state to the global header phase.
module pcap_record_counter #(
  parameter int unsigned TOTAL_WIDTH = pcr_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pcr_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] data_byte
  input  logic                             s_tlast,  // end_of_stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] packet_count, [79:32] payload_total, [80] header_complete, rest 0
  output logic [pcr_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import pcr_pkg::*;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_UNUSED  = 2'd3
  } phase_t;

  localparam logic [TOTAL_WIDTH-1:0] TOTAL_LIM = '1;

  phase_t                 parse_phase, phase_next;
  logic [INDEX_W-1:0]     field_byte_index, index_next;
  logic [WORD_W-1:0]      assembly_word, assembly_next, assembly_shift, rec_len;
  logic                   swap_order, swap_next;
  logic [WORD_W-1:0]      payload_remaining, remaining_next, remaining_dec;
  logic [COUNT_W-1:0]     record_count, count_next;
  logic [TOTAL_WIDTH-1:0] byte_total, total_next;
  logic [TOTAL_WIDTH:0]   total_sum;
  logic [TOTAL_WIDTH_MAX-1:0] total_ext;
  logic                   in_acc;

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  assign assembly_shift = {assembly_word[WORD_W-BYTE_W-1:0], s_tdata};
  assign rec_len        = swap_order ? byte_swap(assembly_word) : assembly_word;
  assign total_sum      = {1'b0, byte_total} + (TOTAL_WIDTH+1)'(rec_len);

  always_comb begin
    phase_next     = parse_phase;
    index_next     = field_byte_index;
    assembly_next  = assembly_word;
    swap_next      = swap_order;
    remaining_next = payload_remaining;
    count_next     = record_count;
    total_next     = byte_total;
    remaining_dec  = (payload_remaining != '0) ? payload_remaining - 1'b1
                                               : payload_remaining;
    unique case (parse_phase)
      PH_PAYLOAD: begin
        remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next = PH_RECORD;
          index_next = '0;
        end
      end
      PH_RECORD: begin
        if (field_byte_index >= LEN_FIRST && field_byte_index <= LEN_LAST) begin
          assembly_next = assembly_shift;
        end
        index_next = field_byte_index + 1'b1;
        if (field_byte_index == RECORD_LAST) begin
          if (record_count != '1) begin
            count_next = record_count + 1'b1;
          end
          // carry out of the sum means the limit was passed
          total_next     = total_sum[TOTAL_WIDTH] ? TOTAL_LIM
                                                  : total_sum[TOTAL_WIDTH-1:0];
          index_next     = '0;
          assembly_next  = '0;
          remaining_next = rec_len;
          phase_next     = (rec_len == '0) ? PH_RECORD : PH_PAYLOAD;
        end
      end
      default: begin
        // global header; the unused code behaves the same
        phase_next = PH_GLOBAL;
        if (field_byte_index <= MAGIC_LAST) begin
          assembly_next = assembly_shift;
        end
        if (field_byte_index == MAGIC_LAST) begin
          swap_next = (assembly_shift == LE_MAGIC);
        end
        index_next = field_byte_index + 1'b1;
        if (field_byte_index == GLOBAL_LAST) begin
          phase_next    = PH_RECORD;
          index_next    = '0;
          assembly_next = '0;
        end
      end
    endcase
  end

  assign total_ext = TOTAL_WIDTH_MAX'(total_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_GLOBAL;
      field_byte_index  <= '0;
      assembly_word     <= '0;
      swap_order        <= 1'b0;
      payload_remaining <= '0;
      record_count      <= '0;
      byte_total        <= '0;
    end else if (in_acc) begin
      if (s_tlast) begin
        // file done: back to reset state for the next one
        parse_phase       <= PH_GLOBAL;
        field_byte_index  <= '0;
        assembly_word     <= '0;
        swap_order        <= 1'b0;
        payload_remaining <= '0;
        record_count      <= '0;
        byte_total        <= '0;
      end else begin
        parse_phase       <= phase_next;
        field_byte_index  <= index_next;
        assembly_word     <= assembly_next;
        swap_order        <= swap_next;
        payload_remaining <= remaining_next;
        record_count      <= count_next;
        byte_total        <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tlast) begin
      m_tdata <= OUT_DATA_W'({(phase_next != PH_GLOBAL),
                              total_ext[PAYLOAD_W-1:0],
                              count_next});
    end
  end

endmodule

// ----- tb/sv/tb_pcap_record_counter.sv -----
// Testbench for pcap_record_counter: streams capture files byte by byte and
// checks the per-file record count, payload total and header flag.
// Depends on pcr_pkg and the pcap_record_counter RTL.
`timescale 1ns / 100ps

module tb_pcap_record_counter;
  import pcr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_BYTES    = 660;
  localparam logic [WORD_W-1:0] BE_MAGIC = 32'ha1b2_c3d4;

  typedef enum logic [1:0] {PH_GLOBAL, PH_RECORD, PH_PAYLOAD} parse_phase_t;
  typedef enum int {MAGIC_LE, MAGIC_BE, MAGIC_OTHER} magic_kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   packets;
    logic [PAYLOAD_W-1:0] payload;
    logic                 header_ok;
  } file_summary_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;  // [7:0] data_byte
  logic                  s_tlast = 1'b0;  // end_of_stream
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [31:0] packet_count, [79:32] payload_total, [80] header_complete
  logic [OUT_DATA_W-1:0] m_tdata;

  pcap_record_counter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- parser copy
  parse_phase_t        phase;
  logic [INDEX_W-1:0]  field_idx;
  logic [WORD_W-1:0]   magic_word;
  logic                little_endian;
  logic [7:0]          len_bytes [4];
  logic [WORD_W-1:0]   skip_left;
  logic [COUNT_W-1:0]  record_total;
  logic [63:0]         length_sum;

  file_summary_t       expected_files [$];
  logic [7:0]          capture [$];
  int                  mismatches = 0;
  int                  burst_left = 0;
  int                  hold_request = 0;

  task automatic clear_parser();
    phase         = PH_GLOBAL;
    field_idx     = '0;
    magic_word    = '0;
    little_endian = 1'b0;
    skip_left     = '0;
    record_total  = '0;
    length_sum    = '0;
    foreach (len_bytes[i]) len_bytes[i] = '0;
  endtask

  task automatic count_byte(input logic [7:0] b, input logic last);
    logic [WORD_W-1:0] len;
    logic [63:0]       sum_max;
    sum_max = (64'd1 << TOTAL_WIDTH_DEF) - 64'd1;
    case (phase)
      PH_PAYLOAD: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          phase     = PH_RECORD;
          field_idx = '0;
        end
      end
      PH_RECORD: begin
        if (field_idx >= 8 && field_idx < 12) len_bytes[field_idx - 8] = b;
        field_idx++;
        if (field_idx == 16) begin
          len = little_endian ? {len_bytes[3], len_bytes[2], len_bytes[1], len_bytes[0]}
                              : {len_bytes[0], len_bytes[1], len_bytes[2], len_bytes[3]};
          if (record_total != '1) record_total++;
          if (length_sum > sum_max - len) length_sum = sum_max;
          else length_sum += len;
          field_idx = '0;
          skip_left = len;
          phase     = (len == 0) ? PH_RECORD : PH_PAYLOAD;
        end
      end
      default: begin
        phase = PH_GLOBAL;
        if (field_idx < 4) magic_word = {magic_word[23:0], b};
        if (field_idx == 3) little_endian = (magic_word == LE_MAGIC);
        field_idx++;
        if (field_idx == 24) begin
          phase     = PH_RECORD;
          field_idx = '0;
        end
      end
    endcase
    if (last) begin
      expected_files.push_back('{record_total, length_sum[PAYLOAD_W-1:0],
                                 phase != PH_GLOBAL});
      clear_parser();
    end
  endtask

  task automatic check_summary();
    file_summary_t        want;
    logic [COUNT_W-1:0]   got_packets;
    logic [PAYLOAD_W-1:0] got_payload;
    logic                 got_header;
    got_packets = m_tdata[COUNT_W-1:0];
    got_payload = m_tdata[COUNT_W +: PAYLOAD_W];
    got_header  = m_tdata[COUNT_W + PAYLOAD_W];
    if (expected_files.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
      mismatches++;
    end else begin
      want = expected_files.pop_front();
      if (got_packets !== want.packets) begin
        $display("%0t: packet_count expected %0d actual %0d",
                 $time, want.packets, got_packets);
        mismatches++;
      end
      if (got_payload !== want.payload) begin
        $display("%0t: payload_total expected %0d actual %0d",
                 $time, want.payload, got_payload);
        mismatches++;
      end
      if (got_header !== want.header_ok) begin
        $display("%0t: header_complete expected %0b actual %0b",
                 $time, want.header_ok, got_header);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
    end else begin
      if (s_tvalid && s_tready) count_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_summary();
    end
  end

  // -------------------------------------------------------------- watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- receiver
  int hold_left = 0;
  int rx_mode   = 0;
  int rx_tick   = 0;
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request <= 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
      rx_tick++;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_tick % 16) < 11;
      endcase
    end
  end

  // -------------------------------------------------------------- sender
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_capture();
    for (int i = 0; i < capture.size(); i++)
      send_byte(capture[i], i == capture.size() - 1);
    capture.delete();
  endtask

  // drop valid and wait for every pending file summary
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_files.size() != 0) @(posedge clk);
  endtask

  task automatic put_global(input magic_kind_t kind);
    logic [WORD_W-1:0] magic;
    case (kind)
      MAGIC_LE: magic = LE_MAGIC;
      MAGIC_BE: magic = BE_MAGIC;
      default:  magic = $urandom;
    endcase
    for (int i = 3; i >= 0; i--) capture.push_back(magic[i*8 +: 8]);
    repeat (20) capture.push_back($urandom_range(0, 255));
  endtask

  task automatic put_record(input logic [WORD_W-1:0] len, input logic le);
    repeat (8) capture.push_back($urandom_range(0, 255));
    for (int i = 0; i < 4; i++)
      capture.push_back(le ? len[i*8 +: 8] : len[(3-i)*8 +: 8]);
    repeat (4) capture.push_back($urandom_range(0, 255));
  endtask

  task automatic put_payload(input int n);
    repeat (n) capture.push_back($urandom_range(0, 255));
  endtask

  task automatic trim_capture(input int n);
    capture = capture[0:n-1];
  endtask

  // -------------------------------------------------------------- tests
  // three records ending on a zero-length header; payload uses 00 and ff
  task automatic test_little_endian_records();
    put_global(MAGIC_LE);
    put_record(3, 1'b1);
    capture.push_back(8'h00);
    capture.push_back(8'hff);
    capture.push_back(8'h00);
    put_record(1, 1'b1);
    capture.push_back(8'hff);
    put_record(0, 1'b1);
    send_capture();
    finish_phase();
  endtask

  // second record header is cut off and must not count
  task automatic test_big_endian_short_record();
    put_global(MAGIC_BE);
    put_record(2, 1'b0);
    put_payload(2);
    put_record(32'h0102_0304, 1'b0);
    trim_capture(capture.size() - 11);
    send_capture();
    finish_phase();
  endtask

  task automatic test_global_header_edges();
    capture.push_back(8'hd4);
    send_capture();
    put_global(MAGIC_LE);
    trim_capture(10);
    send_capture();
    put_global(MAGIC_OTHER);
    trim_capture(23);
    send_capture();
    put_global(MAGIC_OTHER);
    send_capture();
    finish_phase();
  endtask

  // huge lengths, stream ends inside the payload
  task automatic test_truncated_payload();
    put_global(MAGIC_LE);
    put_record(32'hffff_ffff, 1'b1);
    put_payload(5);
    send_capture();
    put_global(MAGIC_BE);
    put_record(32'h8000_0001, 1'b0);
    put_payload(3);
    send_capture();
    finish_phase();
  endtask

  // receiver holds off while short files keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_request <= HOLD_OFF_CYCLES;
    repeat (10) begin
      put_payload($urandom_range(1, 3));
      send_capture();
    end
    finish_phase();
  endtask

  task automatic test_random_captures();
    int          sent;
    int          len;
    int          tail;
    magic_kind_t kind;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        put_payload($urandom_range(1, 40));
      end else begin
        kind = $urandom_range(0, 1) ? MAGIC_LE
                                    : ($urandom_range(0, 1) ? MAGIC_BE : MAGIC_OTHER);
        put_global(kind);
        repeat ($urandom_range(0, 3)) begin
          len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          put_record(len, kind == MAGIC_LE);
          put_payload(len);
        end
        tail = $urandom_range(0, 3);
        if (tail == 0) begin
          put_record($urandom, kind == MAGIC_LE);
          put_payload($urandom_range(0, 8));
        end else if (tail == 1) begin
          trim_capture($urandom_range(1, capture.size()));
        end
      end
      sent += capture.size();
      send_capture();
    end
    finish_phase();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_little_endian_records();
    test_big_endian_short_record();
    test_global_header_edges();
    test_truncated_payload();
    test_output_backpressure();
    test_random_captures();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
